/* design/ppt_pkg.sv */
package ppt_pkg;

  localparam int LOG_DEPTH_DEF = 64;

  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = 6;
  localparam int SLOT_W      = 6;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 56;

  // request kinds carried on in_tuser
  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

endpackage

/* design/ppt_ram.sv */
module ppt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/ppt_ctrl.sv */
module ppt_ctrl #(
  parameter int LOG_DEPTH = ppt_pkg::LOG_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         upd,
  input  logic                         req_read,
  input  logic                         trigger_hit,
  input  logic [ppt_pkg::POS_W-1:0]    read_position,
  output logic [$clog2(LOG_DEPTH)-1:0] slot,
  output logic                         rec_post
);
  import ppt_pkg::*;

  localparam int AW      = $clog2(LOG_DEPTH);
  localparam int QW      = AW - 2;
  localparam int XW      = (AW > POS_W) ? AW : POS_W;
  localparam int QUARTER = LOG_DEPTH / 4;
  localparam int HALF    = LOG_DEPTH / 2;

  logic [AW-1:0] post_rem_r, post_rem_nxt;
  logic [AW-1:0] win_base_r, win_base_nxt;
  logic [AW-1:0] post_base_r, post_base_nxt;
  logic [AW-1:0] step_r, step_nxt;
  logic [AW-1:0] snap_base_r, snap_base_nxt;
  logic [QW-1:0] snap_idx_r, snap_idx_nxt;

  logic [AW-1:0] prem_t, pbase_t, step_t;
  logic [AW-1:0] st_slot, rd_slot, step_inc;
  logic [QW-1:0] win_step_inc, pre_idx;
  logic [XW-1:0] pos_x;

  // read address: pre-trigger window oldest first, then post-trigger area
  always_comb begin
    pos_x   = XW'(read_position);
    pre_idx = snap_idx_r + QW'(pos_x);
    if (pos_x < XW'(QUARTER)) begin
      rd_slot = snap_base_r + AW'(pre_idx);
    end else begin
      rd_slot = post_base_r + AW'(pos_x - XW'(QUARTER));
    end
  end

  always_comb begin
    prem_t        = post_rem_r;
    pbase_t       = post_base_r;
    step_t        = step_r;
    snap_base_nxt = snap_base_r;
    snap_idx_nxt  = snap_idx_r;
    win_base_nxt  = win_base_r;
    // a trigger restarts the post count and snapshots the window position
    if (trigger_hit) begin
      prem_t        = AW'(HALF);
      pbase_t       = win_base_r + AW'(QUARTER);
      snap_base_nxt = win_base_r;
      snap_idx_nxt  = step_r[QW-1:0];
      step_t        = '0;
    end
    post_base_nxt = pbase_t;
    step_inc      = step_t + AW'(1);
    win_step_inc  = step_t[QW-1:0] + QW'(1);
    if (prem_t != '0) begin
      st_slot      = pbase_t + step_t;
      post_rem_nxt = prem_t - AW'(1);
      step_nxt     = step_inc;
      if (post_rem_nxt == '0) begin
        win_base_nxt = st_slot + AW'(1);
        step_nxt     = '0;
      end
    end else begin
      st_slot      = win_base_r + step_t;
      post_rem_nxt = prem_t;
      step_nxt     = AW'(win_step_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_rem_r  <= '0;
      win_base_r  <= '0;
      post_base_r <= AW'(QUARTER);
      step_r      <= '0;
      snap_base_r <= '0;
      snap_idx_r  <= '0;
    end else if (upd) begin
      post_rem_r  <= post_rem_nxt;
      win_base_r  <= win_base_nxt;
      post_base_r <= post_base_nxt;
      step_r      <= step_nxt;
      snap_base_r <= snap_base_nxt;
      snap_idx_r  <= snap_idx_nxt;
    end
  end

  assign slot     = req_read ? rd_slot : st_slot;
  assign rec_post = req_read ? (post_rem_r != '0) : (post_rem_nxt != '0);

endmodule

/* design/pre_post_trigger_capture_buffer_top.sv */
// channel | direction | tdata (low bit up)                                  | tuser
// in_     | slave     | trigger_hit, sample_x, sample_y, sample_z,          | req_type
//         |           | read_position, pad to 56                            |
// out_    | master    | out_x, out_y, out_z, slot_used, recording_post,     | -
//         |           | pad to 56                                           |
// One beat accepted per cycle unless a stall or the clearing pass holds in_tready low.
// The single store port makes one access per beat: a write for a sample, a read for a
// capture request, with the read data registered as the result stage.
// After reset a clearing pass zeroes every store entry with in_tready low.
// A stalled result holds in the result stage while one more beat waits in the input stage.
module pre_post_trigger_capture_buffer_top #(
  parameter int LOG_DEPTH = ppt_pkg::LOG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // trigger_hit, sample_x, sample_y, sample_z, read_position
  input  logic [ppt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [ppt_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_x, out_y, out_z, slot_used, recording_post
  output logic [ppt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ppt_pkg::*;

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int DW = 3 * SAMPLE_W;

  logic                       s1_v_r;
  logic                       s1_req_r;
  logic                       s1_trig_r;
  logic signed [SAMPLE_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [POS_W-1:0]           s1_pos_r;

  logic                       s2_v_r;
  logic                       s2_store_r;
  logic signed [SAMPLE_W-1:0] s2_x_r, s2_y_r, s2_z_r;
  logic [SLOT_W-1:0]          s2_slot_r;
  logic                       s2_rec_r;

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          in_fire, fire1, s1_store, s1_read;
  logic [AW-1:0] slot;
  logic          rec_post;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic signed [SAMPLE_W-1:0] res_x, res_y, res_z;

  assign fire1     = s1_v_r && (!s2_v_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_v_r || fire1);
  assign in_fire   = in_tvalid && in_tready;
  assign s1_store  = (s1_req_r == REQ_STORE);
  assign s1_read   = (s1_req_r == REQ_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (fire1) begin
        s1_v_r <= 1'b0;
      end
      if (fire1) begin
        s2_v_r <= 1'b1;
      end else if (out_tready) begin
        s2_v_r <= 1'b0;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(LOG_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= in_tuser[0];
      s1_trig_r <= in_tdata[0];
      s1_x_r    <= in_tdata[SAMPLE_W:1];
      s1_y_r    <= in_tdata[2*SAMPLE_W:SAMPLE_W+1];
      s1_z_r    <= in_tdata[3*SAMPLE_W:2*SAMPLE_W+1];
      s1_pos_r  <= in_tdata[3*SAMPLE_W+POS_W:3*SAMPLE_W+1];
    end
    if (fire1) begin
      s2_store_r <= s1_store;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_z_r     <= s1_z_r;
      s2_slot_r  <= SLOT_W'(slot);
      s2_rec_r   <= rec_post;
    end
  end

  ppt_ctrl #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (fire1 && s1_store),
    .req_read      (s1_read),
    .trigger_hit   (s1_trig_r),
    .read_position (s1_pos_r),
    .slot          (slot),
    .rec_post      (rec_post)
  );

  // clearing pass owns the port until it ends
  assign ram_we    = clr_busy_r || (fire1 && s1_store);
  assign ram_re    = fire1 && s1_read;
  assign ram_addr  = clr_busy_r ? clr_addr_r : slot;
  assign ram_wdata = clr_busy_r ? '0 : {s1_z_r, s1_y_r, s1_x_r};

  ppt_ram #(
    .WIDTH (DW),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // a store echoes its own sample, a read takes the registered store data
  assign res_x = s2_store_r ? s2_x_r : ram_rdata[SAMPLE_W-1:0];
  assign res_y = s2_store_r ? s2_y_r : ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
  assign res_z = s2_store_r ? s2_z_r : ram_rdata[3*SAMPLE_W-1:2*SAMPLE_W];

  assign out_tvalid = s2_v_r;
  assign out_tdata  = {1'b0, s2_rec_r, s2_slot_r, res_z, res_y, res_x};

endmodule

/* design/ppt_chk.sv */
module ppt_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ppt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [ppt_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ppt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // reset empties the result stage and starts the clearing pass
  a_rst_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("result valid or input ready right after reset");

  // an accepted beat is checked to lead to a result beat on offer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted beat produced no result in time");

endmodule

bind pre_post_trigger_capture_buffer_top ppt_chk u_ppt_chk (.*);
